### rtl/core/pdtr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtr_pkg
// Types and constants shared by the proof step trim and renumber core.
// ----------------------------------------------------------------------------
package pdtr_pkg;

    localparam int MAX_IDS_DEF     = 4096;
    localparam int STACK_DEPTH_DEF = 8192;

    localparam logic [1:0] FUNC_DEFINE = 2'd0;
    localparam logic [1:0] FUNC_FINAL  = 2'd1;
    localparam logic [1:0] FUNC_EMIT   = 2'd2;

    localparam logic [1:0] KIND_INIT = 2'd0;
    localparam logic [1:0] KIND_RED  = 2'd1;
    localparam logic [1:0] KIND_RES  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DROPPED   = 3'd1;
    localparam logic [2:0] ST_UNDEF     = 3'd2;
    localparam logic [2:0] ST_MALFORMED = 3'd3;
    localparam logic [2:0] ST_CUBE      = 3'd4;
    localparam logic [2:0] ST_REDEF     = 3'd5;

    localparam logic [12:0] USE_MAX = 13'd8191;
    localparam logic [11:0] CID_MAX = 12'd4095;

    localparam logic CFG_CLAUSE_COUNT = 1'b0;
    localparam logic CFG_SAT_MODE     = 1'b1;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] step_id;
        logic [11:0] ante1_id;
        logic [11:0] ante2_id;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] new_id;
        logic [11:0] out_ante1;
        logic [11:0] out_ante2;
        logic        ante1_last_use;
        logic        ante2_last_use;
        logic        is_cube;
        logic [11:0] active_initial;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLEAR,
        S_RD1,      // entry reads for the step (and antecedents) in flight
        S_DEF_CHK,
        S_FIN_CHK,
        S_EMIT_CHK,
        S_EMIT_P,   // antecedent p data available
        S_EMIT_Q,   // antecedent q data available
        S_EMIT_WR,
        S_CH_RD,    // chase: read entry tid
        S_CH_EV,
        S_CH_FIX_RD,
        S_CH_FIX_EV,
        S_MK_POP,
        S_MK_RD,
        S_MK_EV,
        S_MK_B,
        S_NUM,
        S_NUM_EV,
        S_DONE
    } state_t;

endpackage

### rtl/core/proof_dag_trim_and_renumber_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proof_dag_trim_and_renumber_core
// Keeps a table of proof steps, marks the steps reachable from the final one
// and hands out compressed ids with antecedent last-use flags.
// ----------------------------------------------------------------------------
//  Channel   Signals                            Transaction
//  command   start, busy, cmd                   start && !busy
//  result    done, result                       done (one cycle, no stall)
//  config    cfg_valid, cfg_ready, cfg_index,   cfg_valid && cfg_ready
//            cfg_data
//
// After reset a clearing pass walks the step table, one entry per cycle;
// busy stays high and no command is taken, while configuration writes are
// taken throughout. The entry memory has a single read port whose data
// arrives in the cycle after the address. done rises in the same cycle that
// busy drops, and a new command can be taken in that cycle. A final command
// walks the graph, visiting each reachable step and chasing reduction links,
// and then numbers the formula clauses in UNSAT mode. The result receiver
// cannot stall; result holds its value until the next command is taken.
// ----------------------------------------------------------------------------
module proof_dag_trim_and_renumber_core #(
    parameter int MAX_IDS     = pdtr_pkg::MAX_IDS_DEF,
    parameter int STACK_DEPTH = pdtr_pkg::STACK_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pdtr_pkg::cmd_t    cmd,
    output logic              done,
    output pdtr_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [11:0]       cfg_data
);

    localparam int AW = $clog2(MAX_IDS);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int TW = SW + 1;

    // Entry word: valid, kind, link_a, link_b / new id, renumbered, use count.
    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [11:0] la;
        logic [11:0] lb;
        logic        ren;
        logic [12:0] uc;
    } entry_t;

    entry_t             mem [MAX_IDS];
    logic [11:0]        stk [STACK_DEPTH];

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    entry_t             wdata, rdata;
    logic               swe;
    logic [SW-1:0]      saddr_w, saddr_r;
    logic [11:0]        sdata_w, sdata_r;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
        if (swe)
        begin
            stk[saddr_w] <= sdata_w;
        end
        sdata_r <= stk[saddr_r];
    end

    pdtr_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    logic [11:0] fcc_reg, fcc_next;
    logic        sat_reg, sat_next;
    logic        phase_reg, phase_next;
    logic [11:0] ncid_reg, ncid_next;
    logic [TW-1:0] top_reg, top_next;
    logic [11:0] fin_reg, fin_next;
    logic [AW:0] clr_reg, clr_next;
    pdtr_pkg::cmd_t cmd_reg, cmd_next;
    pdtr_pkg::result_t res_reg, res_next;
    logic        done_reg, done_next;
    // chase registers: start id, current tid, fix cursor
    logic [11:0] ch_id_reg, ch_id_next, tid_reg, tid_next, cur_reg, cur_next;
    // mark registers: popped id, its entry, chased a
    logic [11:0] mk_id_reg, mk_id_next, mk_a_reg, mk_a_next;
    entry_t      e_reg, e_next, p_reg, p_next;
    logic [1:0]  sub_reg, sub_next;
    logic [11:0] act_reg, act_next;

    function automatic logic in_tab(input logic [11:0] id);
        in_tab = (id != 12'd0) && ({20'd0, id} < 32'(MAX_IDS));
    endfunction

    function automatic logic [1:0] kind_of(input entry_t e, input logic [11:0] id);
        if (!in_tab(id) || !e.valid || e.kind > pdtr_pkg::KIND_RES)
        begin
            kind_of = pdtr_pkg::KIND_INIT;
        end
        else
        begin
            kind_of = e.kind;
        end
    endfunction

    function automatic logic [12:0] inc_uc(input logic [12:0] u);
        inc_uc = (u < pdtr_pkg::USE_MAX) ? u + 13'd1 : u;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdtr_pkg::S_CLEAR;
            ret_reg   <= pdtr_pkg::S_IDLE;
            fcc_reg   <= '0;
            sat_reg   <= 1'b0;
            phase_reg <= 1'b0;
            ncid_reg  <= 12'd1;
            top_reg   <= '0;
            fin_reg   <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            sub_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fcc_reg   <= fcc_next;
            sat_reg   <= sat_next;
            phase_reg <= phase_next;
            ncid_reg  <= ncid_next;
            top_reg   <= top_next;
            fin_reg   <= fin_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        res_reg   <= res_next;
        ch_id_reg <= ch_id_next;
        tid_reg   <= tid_next;
        cur_reg   <= cur_next;
        mk_id_reg <= mk_id_next;
        mk_a_reg  <= mk_a_next;
        e_reg     <= e_next;
        p_reg     <= p_next;
        act_reg   <= act_next;
    end

    assign busy      = (state_reg != pdtr_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = res_reg;

    always_comb
    begin
        logic [11:0] id, a1, a2;
        logic [1:0]  k;
        logic        def;
        entry_t      ne;

        state_next = state_reg;
        ret_next   = ret_reg;
        fcc_next   = fcc_reg;
        sat_next   = sat_reg;
        phase_next = phase_reg;
        ncid_next  = ncid_reg;
        top_next   = top_reg;
        fin_next   = fin_reg;
        clr_next   = clr_reg;
        cmd_next   = cmd_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        ch_id_next = ch_id_reg;
        tid_next   = tid_reg;
        cur_next   = cur_reg;
        mk_id_next = mk_id_reg;
        mk_a_next  = mk_a_reg;
        e_next     = e_reg;
        p_next     = p_reg;
        sub_next   = sub_reg;
        act_next   = act_reg;
        we         = 1'b0;
        waddr      = '0;
        wdata      = '0;
        raddr      = '0;
        swe        = 1'b0;
        saddr_w    = '0;
        sdata_w    = '0;
        saddr_r    = '0;
        id         = cmd_reg.step_id;
        a1         = cmd_reg.ante1_id;
        a2         = cmd_reg.ante2_id;
        k          = '0;
        def        = 1'b0;
        ne         = rdata;

        if (cfg_valid)
        begin
            if (cfg_index == pdtr_pkg::CFG_CLAUSE_COUNT)
            begin
                fcc_next = cfg_data;
            end
            else
            begin
                sat_next = cfg_data[0];
            end
        end

        case (state_reg)
            pdtr_pkg::S_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg[AW-1:0];
                wdata = '0;
                clr_next = clr_reg + (AW+1)'(1);
                if (clr_reg == (AW+1)'(MAX_IDS - 1))
                begin
                    state_next = pdtr_pkg::S_IDLE;
                end
            end
            pdtr_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    res_next = '0;
                    sub_next = '0;
                    raddr    = AW'(cmd.ante1_id);
                    state_next = pdtr_pkg::S_RD1;
                end
            end
            pdtr_pkg::S_RD1:
            begin
                // Gather up to three entry words: ante1, ante2, step.
                case (sub_reg)
                    2'd0:
                    begin
                        p_next   = rdata;
                        raddr    = AW'(a2);
                        sub_next = 2'd1;
                    end
                    2'd1:
                    begin
                        e_next   = rdata;
                        raddr    = AW'(id);
                        sub_next = 2'd2;
                    end
                    default:
                    begin
                        // Keep the step address so its word is still there
                        // in the check state.
                        raddr    = AW'(id);
                        sub_next = '0;
                        case (cmd_reg.func)
                            pdtr_pkg::FUNC_DEFINE: state_next = pdtr_pkg::S_DEF_CHK;
                            pdtr_pkg::FUNC_FINAL:  state_next = pdtr_pkg::S_FIN_CHK;
                            pdtr_pkg::FUNC_EMIT:   state_next = pdtr_pkg::S_EMIT_CHK;
                            default:
                            begin
                                res_next.status = pdtr_pkg::ST_MALFORMED;
                                state_next = pdtr_pkg::S_DONE;
                            end
                        endcase
                    end
                endcase
            end
            pdtr_pkg::S_DEF_CHK:
            begin
                // p_reg = ante1 entry, e_reg = ante2 entry, rdata = step entry
                k = (a1 == 12'd0) ? pdtr_pkg::KIND_INIT
                  : ((a2 == 12'd0) ? pdtr_pkg::KIND_RED : pdtr_pkg::KIND_RES);
                if (k != pdtr_pkg::KIND_INIT && !(in_tab(a1) && (p_reg.valid || a1 <= fcc_reg)))
                begin
                    res_next.status = pdtr_pkg::ST_UNDEF;
                end
                else if (k == pdtr_pkg::KIND_RES && !(in_tab(a2) && (e_reg.valid || a2 <= fcc_reg)))
                begin
                    res_next.status = pdtr_pkg::ST_UNDEF;
                end
                else if (!in_tab(id))
                begin
                    res_next.status = pdtr_pkg::ST_MALFORMED;
                end
                else if (rdata.valid || id <= fcc_reg)
                begin
                    res_next.status = pdtr_pkg::ST_REDEF;
                end
                else
                begin
                    we       = 1'b1;
                    waddr    = AW'(id);
                    wdata.valid = 1'b1;
                    wdata.kind  = k;
                    wdata.la    = (k == pdtr_pkg::KIND_INIT) ? 12'd0 : a1;
                    wdata.lb    = (k == pdtr_pkg::KIND_RES) ? a2 : 12'd0;
                    wdata.ren   = 1'b0;
                    wdata.uc    = '0;
                end
                state_next = pdtr_pkg::S_DONE;
            end
            pdtr_pkg::S_FIN_CHK:
            begin
                if (phase_reg)
                begin
                    res_next.status = pdtr_pkg::ST_REDEF;
                    state_next = pdtr_pkg::S_DONE;
                end
                else if (!in_tab(id))
                begin
                    res_next.status = pdtr_pkg::ST_MALFORMED;
                    state_next = pdtr_pkg::S_DONE;
                end
                else if (!(rdata.valid || id <= fcc_reg))
                begin
                    res_next.status = pdtr_pkg::ST_UNDEF;
                    state_next = pdtr_pkg::S_DONE;
                end
                else
                begin
                    ch_id_next = id;
                    tid_next   = id;
                    ret_next   = pdtr_pkg::S_MK_POP;
                    top_next   = '0;
                    raddr      = AW'(id);
                    state_next = pdtr_pkg::S_CH_EV;
                end
            end
            // ---- chase: follow reduction links, bumping use counts ----
            pdtr_pkg::S_CH_RD:
            begin
                raddr      = AW'(tid_reg);
                state_next = pdtr_pkg::S_CH_EV;
            end
            pdtr_pkg::S_CH_EV:
            begin
                if (kind_of(rdata, tid_reg) != pdtr_pkg::KIND_RED)
                begin
                    cur_next   = ch_id_reg;
                    raddr      = AW'(ch_id_reg);
                    state_next = pdtr_pkg::S_CH_FIX_EV;
                end
                else
                begin
                    ne    = rdata;
                    ne.uc = inc_uc(rdata.uc);
                    we    = 1'b1;
                    waddr = AW'(tid_reg);
                    wdata = ne;
                    tid_next = rdata.la;
                    if (rdata.uc != 13'd0)
                    begin
                        cur_next   = ch_id_reg;
                        state_next = pdtr_pkg::S_CH_FIX_RD;
                    end
                    else
                    begin
                        state_next = pdtr_pkg::S_CH_RD;
                    end
                end
            end
            pdtr_pkg::S_CH_FIX_RD:
            begin
                raddr      = AW'(cur_reg);
                state_next = pdtr_pkg::S_CH_FIX_EV;
            end
            pdtr_pkg::S_CH_FIX_EV:
            begin
                if (cur_reg == tid_reg || kind_of(rdata, cur_reg) != pdtr_pkg::KIND_RED)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    ne    = rdata;
                    ne.la = tid_reg;
                    we    = 1'b1;
                    waddr = AW'(cur_reg);
                    wdata = ne;
                    cur_next   = rdata.la;
                    state_next = pdtr_pkg::S_CH_FIX_RD;
                end
            end
            // ---- mark: worklist walk ----
            pdtr_pkg::S_MK_POP:
            begin
                // Chase results return here: push tid, by sub-step.
                case (sub_reg)
                    2'd0:
                    begin
                        fin_next = tid_reg;
                        sub_next = 2'd3;
                        if (top_reg < TW'(STACK_DEPTH))
                        begin
                            swe = 1'b1;
                            saddr_w = top_reg[SW-1:0];
                            sdata_w = tid_reg;
                            top_next = top_reg + TW'(1);
                        end
                    end
                    2'd1:
                    begin
                        // chased a: store and chase b
                        mk_a_next  = tid_reg;
                        ch_id_next = e_reg.lb;
                        tid_next   = e_reg.lb;
                        sub_next   = 2'd2;
                        raddr      = AW'(e_reg.lb);
                        state_next = pdtr_pkg::S_CH_EV;
                    end
                    2'd2:
                    begin
                        // chased b: reread the node, then write links and push
                        raddr      = AW'(mk_id_reg);
                        state_next = pdtr_pkg::S_MK_B;
                    end
                    default:
                    begin
                        if (top_reg == '0)
                        begin
                            phase_next = 1'b1;
                            ncid_next  = 12'd1;
                            act_next   = '0;
                            cur_next   = 12'd1;
                            state_next = pdtr_pkg::S_NUM;
                        end
                        else
                        begin
                            saddr_r  = SW'(top_reg - TW'(1));
                            top_next = top_reg - TW'(1);
                            state_next = pdtr_pkg::S_MK_RD;
                        end
                    end
                endcase
            end
            pdtr_pkg::S_MK_RD:
            begin
                mk_id_next = sdata_r;
                raddr      = AW'(sdata_r);
                state_next = pdtr_pkg::S_MK_EV;
            end
            pdtr_pkg::S_MK_EV:
            begin
                state_next = pdtr_pkg::S_MK_POP;
                sub_next   = 2'd3;
                if (in_tab(mk_id_reg))
                begin
                    ne    = rdata;
                    ne.uc = inc_uc(rdata.uc);
                    we    = 1'b1;
                    waddr = AW'(mk_id_reg);
                    wdata = ne;
                    if (rdata.uc == 13'd0 && kind_of(rdata, mk_id_reg) == pdtr_pkg::KIND_RES)
                    begin
                        e_next     = rdata;
                        ch_id_next = rdata.la;
                        tid_next   = rdata.la;
                        sub_next   = 2'd1;
                        state_next = pdtr_pkg::S_CH_RD;
                    end
                end
            end
            pdtr_pkg::S_MK_B:
            begin
                // Push a then b; a full stack drops pushes.
                case (sub_reg)
                    2'd2:
                    begin
                        ne    = rdata;
                        ne.la = mk_a_reg;
                        ne.lb = tid_reg;
                        we    = 1'b1;
                        waddr = AW'(mk_id_reg);
                        wdata = ne;
                        sub_next = 2'd0;
                        if (top_reg < TW'(STACK_DEPTH))
                        begin
                            swe = 1'b1;
                            saddr_w = top_reg[SW-1:0];
                            sdata_w = mk_a_reg;
                            top_next = top_reg + TW'(1);
                        end
                    end
                    default:
                    begin
                        sub_next = 2'd3;
                        state_next = pdtr_pkg::S_MK_POP;
                        if (top_reg < TW'(STACK_DEPTH))
                        begin
                            swe = 1'b1;
                            saddr_w = top_reg[SW-1:0];
                            sdata_w = tid_reg;
                            top_next = top_reg + TW'(1);
                        end
                    end
                endcase
            end
            // ---- number formula clauses in UNSAT mode ----
            pdtr_pkg::S_NUM:
            begin
                if (sat_reg || cur_reg > fcc_reg || !in_tab(cur_reg))
                begin
                    res_next.new_id         = ncid_reg;
                    res_next.active_initial = act_reg;
                    state_next = pdtr_pkg::S_DONE;
                end
                else
                begin
                    raddr      = AW'(cur_reg);
                    state_next = pdtr_pkg::S_NUM_EV;
                end
            end
            pdtr_pkg::S_NUM_EV:
            begin
                ne     = rdata;
                ne.ren = 1'b1;
                ne.lb  = ncid_reg;
                we     = 1'b1;
                waddr  = AW'(cur_reg);
                wdata  = ne;
                if (ncid_reg < pdtr_pkg::CID_MAX)
                begin
                    ncid_next = ncid_reg + 12'd1;
                end
                if (rdata.uc != 13'd0)
                begin
                    act_next = act_reg + 12'd1;
                end
                cur_next   = cur_reg + 12'd1;
                state_next = pdtr_pkg::S_NUM;
            end
            // ---- emit ----
            pdtr_pkg::S_EMIT_CHK:
            begin
                k   = kind_of(rdata, id);
                def = in_tab(id) && (rdata.valid || id <= fcc_reg);
                e_next = rdata;
                state_next = pdtr_pkg::S_DONE;
                if (!in_tab(id))
                begin
                    res_next.status = pdtr_pkg::ST_MALFORMED;
                end
                else if (!def)
                begin
                    res_next.status = pdtr_pkg::ST_UNDEF;
                end
                else if (k == pdtr_pkg::KIND_RED || rdata.uc == 13'd0)
                begin
                    res_next.status = pdtr_pkg::ST_DROPPED;
                end
                else if (rdata.ren)
                begin
                    res_next.status = pdtr_pkg::ST_REDEF;
                end
                else if (k == pdtr_pkg::KIND_INIT)
                begin
                    if (!sat_reg)
                    begin
                        res_next.status = pdtr_pkg::ST_CUBE;
                    end
                    else
                    begin
                        ne     = rdata;
                        ne.ren = 1'b1;
                        ne.lb  = ncid_reg;
                        we     = 1'b1;
                        waddr  = AW'(id);
                        wdata  = ne;
                        res_next.new_id  = ncid_reg;
                        res_next.is_cube = 1'b1;
                        if (ncid_reg < pdtr_pkg::CID_MAX)
                        begin
                            ncid_next = ncid_reg + 12'd1;
                        end
                    end
                end
                else if (!in_tab(rdata.la) || !in_tab(rdata.lb))
                begin
                    res_next.status = pdtr_pkg::ST_UNDEF;
                end
                else
                begin
                    raddr      = AW'(rdata.la);
                    state_next = pdtr_pkg::S_EMIT_P;
                end
            end
            pdtr_pkg::S_EMIT_P:
            begin
                p_next     = rdata;
                raddr      = AW'(e_reg.lb);
                state_next = pdtr_pkg::S_EMIT_Q;
            end
            pdtr_pkg::S_EMIT_Q:
            begin
                // rdata = q entry; when p == q the decrements stack up.
                if (!p_reg.ren || !rdata.ren)
                begin
                    res_next.status = pdtr_pkg::ST_UNDEF;
                    state_next = pdtr_pkg::S_DONE;
                end
                else
                begin
                    ne    = p_reg;
                    if (ne.uc != 13'd0)
                    begin
                        ne.uc = ne.uc - 13'd1;
                    end
                    res_next.out_ante1      = p_reg.lb;
                    res_next.ante1_last_use = (ne.uc == 13'd0);
                    we    = 1'b1;
                    waddr = AW'(e_reg.la);
                    wdata = ne;
                    p_next = rdata;
                    if (e_reg.la == e_reg.lb)
                    begin
                        p_next = ne;
                    end
                    state_next = pdtr_pkg::S_EMIT_WR;
                end
            end
            pdtr_pkg::S_EMIT_WR:
            begin
                case (sub_reg)
                    2'd0:
                    begin
                        ne = p_reg;
                        if (ne.uc != 13'd0)
                        begin
                            ne.uc = ne.uc - 13'd1;
                        end
                        res_next.out_ante2      = p_reg.lb;
                        res_next.ante2_last_use = (ne.uc == 13'd0);
                        we    = 1'b1;
                        waddr = AW'(e_reg.lb);
                        wdata = ne;
                        sub_next = 2'd1;
                    end
                    default:
                    begin
                        ne     = e_reg;
                        ne.ren = 1'b1;
                        ne.la  = 12'd0;
                        ne.lb  = ncid_reg;
                        we     = 1'b1;
                        waddr  = AW'(id);
                        wdata  = ne;
                        res_next.new_id = ncid_reg;
                        if (ncid_reg < pdtr_pkg::CID_MAX)
                        begin
                            ncid_next = ncid_reg + 12'd1;
                        end
                        state_next = pdtr_pkg::S_DONE;
                    end
                endcase
            end
            pdtr_pkg::S_DONE:
            begin
                done_next  = 1'b1;
                state_next = pdtr_pkg::S_IDLE;
            end
            default:
            begin
                state_next = pdtr_pkg::S_IDLE;
            end
        endcase
    end

endmodule
